// ----- src/fer_pkg.sv -----
// ----------------------------------------------------------------------------
// fer_pkg
// Types, constants and result builders for the fragment event reassembler.
// ----------------------------------------------------------------------------
package fer_pkg;

  localparam int WORD_W   = 16;
  localparam int LEN_W    = 12;
  localparam int STACK_W  = 3;
  localparam int QDEPTH   = 6;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);
  localparam int QIDX_W   = $clog2(QDEPTH);
  localparam int MAX_RES  = 3;

  localparam logic [WORD_W-1:0] TERM_WORD = 16'hffff;
  localparam logic [WORD_W-1:0] CNT_MAX   = 16'hffff;
  localparam int STACK_LSB = 13;
  localparam int MORE_BIT  = 12;

  typedef struct packed {
    logic [WORD_W-1:0]  data_word;
    logic               data_valid;
    logic [STACK_W-1:0] stack_id;
    logic               event_end;
    logic [WORD_W-1:0]  total_words;
  } result_t;

  function automatic result_t mk_data(input logic [WORD_W-1:0] w,
                                      input logic [STACK_W-1:0] stk);
    result_t r;
    r.data_word   = w;
    r.data_valid  = 1'b1;
    r.stack_id    = stk;
    r.event_end   = 1'b0;
    r.total_words = '0;
    return r;
  endfunction

  function automatic result_t mk_end(input logic [STACK_W-1:0] stk,
                                     input logic [WORD_W-1:0] cnt);
    result_t r;
    r.data_word   = '0;
    r.data_valid  = 1'b0;
    r.stack_id    = stk;
    r.event_end   = 1'b1;
    r.total_words = cnt;
    return r;
  endfunction

endpackage

// ----- src/fer_if.sv -----
// ----------------------------------------------------------------------------
// fer_if
// Valid/ready channels: stream words in, reassembled results out.
// ----------------------------------------------------------------------------
interface fer_word_if;
  logic                        valid;
  logic                        ready;
  logic [fer_pkg::WORD_W-1:0]  word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface fer_result_if;
  logic                        valid;
  logic                        ready;
  logic [fer_pkg::WORD_W-1:0]  data_word;
  logic                        data_valid;
  logic [fer_pkg::STACK_W-1:0] stack_id;
  logic                        event_end;
  logic [fer_pkg::WORD_W-1:0]  total_words;

  modport source (output valid, output data_word, output data_valid, output stack_id,
                  output event_end, output total_words, input ready);
  modport sink   (input valid, input data_word, input data_valid, input stack_id,
                  input event_end, input total_words, output ready);
endinterface

// ----- src/fragment_event_reassembler_unit.sv -----
// ----------------------------------------------------------------------------
// fragment_event_reassembler_unit
// Rebuilds events from fragmented 16-bit word streams.
// ----------------------------------------------------------------------------
// in_ch carries one stream word per handshake: a fragment header (stack id,
// continuation bit, payload length) or a payload word. out_ch carries one
// result per handshake: a payload word tagged with the event's stack id, or
// the end word with the event's total word count (saturating at 65535).
// A trailing bus-error terminator (last payload word 0xFFFF) is dropped with
// the word before it, so up to two payload words are held back in the core.
// Each word is decoded in the cycle it is accepted; its results (zero to
// three) enter a six-entry result queue, and the registered queue head
// drives out_ch.
// Throughput is one word per cycle while the queue has room; in_ch.ready
// drops while the queue has fewer than three free entries. A stall on out_ch
// holds the queue head and fills the queue until input is held off.
// Reset (rst_n low, synchronous) empties the queue and waits for a header.
// ----------------------------------------------------------------------------
module fragment_event_reassembler_unit (
  input  logic         clk,
  input  logic         rst_n,
  fer_word_if.sink     in_ch,
  fer_result_if.source out_ch
);
  import fer_pkg::*;

  logic                expect_hdr_r, expect_hdr_nxt;
  logic [LEN_W-1:0]    remain_r, remain_nxt;
  logic                more_r, more_nxt;
  logic [STACK_W-1:0]  stack_r, stack_nxt;
  logic                first_r, first_nxt;
  logic [WORD_W-1:0]   wcnt_r, wcnt_nxt;
  logic [WORD_W-1:0]   h0_r, h0_nxt, h1_r, h1_nxt;
  logic [1:0]          hc_r, hc_nxt;

  result_t             res [MAX_RES];
  logic [1:0]          nres;

  result_t             q_r [QDEPTH];
  result_t             q_nxt [QDEPTH];
  logic [QCNT_W-1:0]   qcnt_r, qcnt_nxt;

  logic accept, pop;

  assign in_ch.ready = (qcnt_r <= QCNT_W'(QDEPTH - MAX_RES));
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;

  always_comb begin
    logic [WORD_W-1:0]  w;
    logic [WORD_W-1:0]  cinc;
    logic [LEN_W-1:0]   len;
    logic [WORD_W-1:0]  last;
    logic               closing;

    w              = in_ch.word;
    cinc           = (wcnt_r == CNT_MAX) ? wcnt_r : wcnt_r + 1'b1;
    len            = w[LEN_W-1:0];
    last           = (hc_r == 2'd2) ? h1_r : h0_r;
    closing        = 1'b0;
    expect_hdr_nxt = expect_hdr_r;
    remain_nxt     = remain_r;
    more_nxt       = more_r;
    stack_nxt      = stack_r;
    first_nxt      = first_r;
    wcnt_nxt       = wcnt_r;
    h0_nxt         = h0_r;
    h1_nxt         = h1_r;
    hc_nxt         = hc_r;
    nres           = 2'd0;
    for (int i = 0; i < MAX_RES; i++) res[i] = '0;

    if (accept) begin
      wcnt_nxt = cinc;
      if (expect_hdr_r) begin
        if (!first_r) stack_nxt = w[WORD_W-1:STACK_LSB];
        first_nxt = 1'b1;
        more_nxt  = w[MORE_BIT];
        if (len == '0) begin
          remain_nxt = '0;
          if (!w[MORE_BIT]) begin
            if (!(hc_r != 2'd0 && last == TERM_WORD)) begin
              if (hc_r != 2'd0) begin
                res[nres] = mk_data(h0_r, stack_nxt);
                nres      = nres + 2'd1;
              end
              if (hc_r == 2'd2) begin
                res[nres] = mk_data(h1_r, stack_nxt);
                nres      = nres + 2'd1;
              end
            end
            closing = 1'b1;
          end
        end else begin
          remain_nxt     = len;
          expect_hdr_nxt = 1'b0;
          if (!w[MORE_BIT] && len == LEN_W'(1) && hc_r == 2'd2) begin
            res[nres] = mk_data(h0_r, stack_nxt);
            nres      = nres + 2'd1;
            h0_nxt    = h1_r;
            hc_nxt    = 2'd1;
          end
        end
      end else if (remain_r <= LEN_W'(1)) begin
        remain_nxt = '0;
        if (more_r) begin
          hc_nxt = hc_r;
          if (hc_r == 2'd2) begin
            res[nres] = mk_data(h0_r, stack_r);
            nres      = nres + 2'd1;
            h0_nxt    = h1_r;
            hc_nxt    = 2'd1;
          end
          if (hc_nxt[0]) h1_nxt = w;
          else           h0_nxt = w;
          hc_nxt         = hc_nxt + 2'd1;
          expect_hdr_nxt = 1'b1;
        end else begin
          hc_nxt = hc_r;
          if (hc_r == 2'd2) begin
            res[nres] = mk_data(h0_r, stack_r);
            nres      = nres + 2'd1;
            h0_nxt    = h1_r;
            hc_nxt    = 2'd1;
          end
          if (w != TERM_WORD) begin
            if (hc_nxt != 2'd0) begin
              res[nres] = mk_data(h0_nxt, stack_r);
              nres      = nres + 2'd1;
            end
            res[nres] = mk_data(w, stack_r);
            nres      = nres + 2'd1;
          end
          closing = 1'b1;
        end
      end else begin
        hc_nxt = hc_r;
        if (!more_r && remain_r == LEN_W'(2)) begin
          if (hc_r != 2'd0) begin
            res[nres] = mk_data(h0_r, stack_r);
            nres      = nres + 2'd1;
          end
          if (hc_r == 2'd2) begin
            res[nres] = mk_data(h1_r, stack_r);
            nres      = nres + 2'd1;
          end
          hc_nxt = 2'd0;
        end else if (hc_r == 2'd2) begin
          res[nres] = mk_data(h0_r, stack_r);
          nres      = nres + 2'd1;
          h0_nxt    = h1_r;
          hc_nxt    = 2'd1;
        end
        if (hc_nxt[0]) h1_nxt = w;
        else           h0_nxt = w;
        hc_nxt     = hc_nxt + 2'd1;
        remain_nxt = remain_r - 1'b1;
      end

      if (closing) begin
        res[nres]      = mk_end(stack_nxt, cinc);
        nres           = nres + 2'd1;
        wcnt_nxt       = '0;
        first_nxt      = 1'b0;
        hc_nxt         = 2'd0;
        expect_hdr_nxt = 1'b1;
        more_nxt       = 1'b0;
        remain_nxt     = '0;
      end
    end
  end

  // Result queue: head at entry 0, shift on pop, append behind the survivors.
  always_comb begin
    logic [QCNT_W-1:0] base;
    logic [QCNT_W-1:0] rel;

    base = qcnt_r - QCNT_W'(pop);
    for (int j = 0; j < QDEPTH; j++) begin
      if (pop && j < QDEPTH - 1) q_nxt[j] = q_r[j + 1];
      else                       q_nxt[j] = q_r[j];
    end
    for (int j = 0; j < QDEPTH; j++) begin
      rel = QCNT_W'(j) - base;
      if (QCNT_W'(j) >= base && rel < QCNT_W'(nres)) q_nxt[j] = res[rel[1:0]];
    end
    qcnt_nxt = base + QCNT_W'(nres);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_hdr_r <= 1'b1;
      remain_r     <= '0;
      more_r       <= 1'b0;
      stack_r      <= '0;
      first_r      <= 1'b0;
      wcnt_r       <= '0;
      hc_r         <= 2'd0;
      qcnt_r       <= '0;
    end else begin
      expect_hdr_r <= expect_hdr_nxt;
      remain_r     <= remain_nxt;
      more_r       <= more_nxt;
      stack_r      <= stack_nxt;
      first_r      <= first_nxt;
      wcnt_r       <= wcnt_nxt;
      hc_r         <= hc_nxt;
      qcnt_r       <= qcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h0_r <= h0_nxt;
    h1_r <= h1_nxt;
    for (int j = 0; j < QDEPTH; j++) q_r[j] <= q_nxt[j];
  end

  assign out_ch.valid       = (qcnt_r != '0);
  assign out_ch.data_word   = q_r[0].data_word;
  assign out_ch.data_valid  = q_r[0].data_valid;
  assign out_ch.stack_id    = q_r[0].stack_id;
  assign out_ch.event_end   = q_r[0].event_end;
  assign out_ch.total_words = q_r[0].total_words;

endmodule

// ----- bench/fragment_event_reassembler_unit_test.sv -----
// ----------------------------------------------------------------------------
// fragment_event_reassembler_unit_test
// Drives fragmented word streams into the reassembler and predicts every
// payload word and end word it must produce. Covers empty fragments, events
// without payload, bus-error terminators at the end of short and long
// fragments, under random idling and backpressure.
// ----------------------------------------------------------------------------
module fragment_event_reassembler_unit_test;
  import fer_pkg::*;

  localparam int IDLE_PCT    = 35;
  localparam int HOLD_CYCLES = 60;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_WORDS = 70;

  class reassembly_scoreboard;
    logic                 expect_hdr;
    logic [LEN_W-1:0]     left;
    logic                 more;
    logic [STACK_W-1:0]   stack;
    logic                 stack_taken;
    logic [WORD_W-1:0]    count;
    logic [WORD_W-1:0]    held [2];
    logic [1:0]           held_n;
    result_t              pending_results [$];
    int                   mismatches;

    function new();
      expect_hdr  = 1'b1;
      left        = '0;
      more        = 1'b0;
      stack       = '0;
      stack_taken = 1'b0;
      count       = '0;
      held[0]     = '0;
      held[1]     = '0;
      held_n      = '0;
      mismatches  = 0;
    endfunction

    function void push_payload(input logic [WORD_W-1:0] w);
      result_t r;
      r.data_word   = w;
      r.data_valid  = 1'b1;
      r.stack_id    = stack;
      r.event_end   = 1'b0;
      r.total_words = '0;
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void pop_oldest();
      push_payload(held[0]);
      held[0] = held[1];
      held_n  = 2'd1;
    endfunction

    function void flush_held();
      for (int i = 0; i < held_n; i++) push_payload(held[i]);
      held_n = '0;
    endfunction

    function void close_event();
      result_t r;
      r.data_word   = '0;
      r.data_valid  = 1'b0;
      r.stack_id    = stack;
      r.event_end   = 1'b1;
      r.total_words = count;
      pending_results.insert(pending_results.size(), r);
      count       = '0;
      stack_taken = 1'b0;
      held_n      = '0;
      expect_hdr  = 1'b1;
      more        = 1'b0;
      left        = '0;
    endfunction

    function void take_word(input logic [WORD_W-1:0] w);
      logic [LEN_W-1:0] len;
      len = w[LEN_W-1:0];
      if (count != CNT_MAX) count++;
      if (expect_hdr) begin
        if (!stack_taken) begin
          stack       = w[STACK_LSB +: STACK_W];
          stack_taken = 1'b1;
        end
        more = w[MORE_BIT];
        left = len;
        if (len == 0) begin
          if (!more) begin
            if (held_n > 0 && held[held_n - 1] == TERM_WORD) held_n = '0;
            else flush_held();
            close_event();
          end
        end else begin
          expect_hdr = 1'b0;
          if (!more && len == 1 && held_n >= 2) pop_oldest();
        end
        return;
      end
      if (left <= 1) begin
        left = '0;
        if (more) begin
          if (held_n >= 2) pop_oldest();
          held[held_n[0]] = w;
          held_n++;
          expect_hdr = 1'b1;
        end else begin
          if (held_n > 1) pop_oldest();
          if (w == TERM_WORD) begin
            held_n = '0;
          end else begin
            flush_held();
            push_payload(w);
          end
          close_event();
        end
        return;
      end
      if (!more && left == 2) flush_held();
      else if (held_n >= 2) pop_oldest();
      held[held_n[0]] = w;
      held_n++;
      left--;
    endfunction

    task report(input string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch: %s", msg);
    endtask

    task check_result(input result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected word data=%h end=%b total=%h",
                         got.data_word, got.event_end, got.total_words));
        return;
      end
      want = pending_results.pop_front();
      if (got.data_word !== want.data_word)
        report($sformatf("data_word got %h want %h", got.data_word, want.data_word));
      if (got.data_valid !== want.data_valid)
        report($sformatf("data_valid got %b want %b", got.data_valid, want.data_valid));
      if (got.stack_id !== want.stack_id)
        report($sformatf("stack_id got %h want %h", got.stack_id, want.stack_id));
      if (got.event_end !== want.event_end)
        report($sformatf("event_end got %b want %b", got.event_end, want.event_end));
      if (got.total_words !== want.total_words)
        report($sformatf("total_words got %h want %h", got.total_words, want.total_words));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  fer_word_if   in_ch ();
  fer_result_if out_ch ();

  fragment_event_reassembler_unit uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  reassembly_scoreboard board = new();

  logic in_idle_on  = 1'b1;
  logic out_idle_on = 1'b1;
  int   hold_asks   = 0;
  int   words_sent  = 0;
  int   quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_word(input logic [WORD_W-1:0] w);
    while (in_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.word  <= w;
    do @(posedge clk); while (!in_ch.ready);
    board.take_word(w);
    words_sent++;
  endtask

  task automatic send_event(input int frags, input int min_len, input int max_len,
                            input logic with_term);
    logic [31:0]       pick;
    logic [LEN_W-1:0]  len;
    logic              last;
    logic [WORD_W-1:0] w;
    for (int f = 0; f < frags; f++) begin
      last = (f == frags - 1);
      pick = $urandom_range(max_len, min_len);
      len  = pick[LEN_W-1:0];
      if (last && with_term && len == 0) len = 1;
      pick = $urandom;
      send_word({pick[2:0], !last, len});
      for (int i = 0; i < len; i++) begin
        pick = $urandom;
        w = pick[WORD_W-1:0];
        if ($urandom_range(0, 7) == 0) w = TERM_WORD;
        if (last && with_term && i == len - 1) w = TERM_WORD;
        send_word(w);
      end
    end
  endtask

  // keep noise headers short, then run out the current fragment
  task automatic send_noise(input int n);
    logic [31:0] pick;
    logic [WORD_W-1:0] w;
    for (int i = 0; i < n; i++) begin
      pick = $urandom;
      w = pick[WORD_W-1:0];
      if (board.expect_hdr) w[LEN_W-1:3] = '0;
      send_word(w);
    end
    while (!board.expect_hdr) begin
      pick = $urandom;
      send_word(pick[WORD_W-1:0]);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending_results.size() != 0);
  endtask

  initial begin : word_side
    logic [WORD_W-1:0] opening [$];
    logic [31:0]       pick;
    int                mark;
    int                round;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.word  <= '0;
    opening = '{16'h0000,
                16'hE002, 16'h0000, 16'hFFFF,
                16'hA001, 16'hFFFF,
                16'h7000, 16'h1002, 16'h1234, 16'hFFFF, 16'h0000,
                16'h5002, 16'h8000, 16'h4321, 16'h0001, 16'h7FFF,
                16'h2003, 16'hFFFF, 16'h0001, 16'hAAAA,
                16'h3000, 16'h0000};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening[i]) send_word(opening[i]);

    mark  = words_sent;
    round = 0;
    while (words_sent - mark < RANDOM_WORDS) begin
      if (round == 2) hold_asks++;
      if (round == 4) wait_drained();
      pick = $urandom_range(0, 9);
      if (pick < 6)
        send_event(1 + $urandom_range(0, 3), 0, 6, $urandom_range(0, 2) == 0);
      else if (pick < 8)
        send_event(1 + $urandom_range(0, 2), 0, 2, 1'b1);
      else if (pick == 8)
        send_event(1, 7, 40, $urandom_range(0, 1) == 0);
      else
        send_noise(1 + $urandom_range(0, 3));
      round++;
    end

    // run a long stretch with no idling on either side
    wait_drained();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    for (int i = 0; i < 4; i++)
      send_event(1 + $urandom_range(0, 2), 1, 6, $urandom_range(0, 1) == 0);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;

    hold_asks++;
    for (int i = 0; i < 3; i++)
      send_event(1 + $urandom_range(0, 3), 0, 6, $urandom_range(0, 1) == 0);

    wait_drained();
    repeat (8) @(posedge clk);
    if (board.mismatches == 0 && board.pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin : result_side
    result_t got;
    int      hold_left;
    int      holds_seen;
    hold_left    = 0;
    holds_seen   = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.data_word   = out_ch.data_word;
        got.data_valid  = out_ch.data_valid;
        got.stack_id    = out_ch.stack_id;
        got.event_end   = out_ch.event_end;
        got.total_words = out_ch.total_words;
        board.check_result(got);
      end
      if (holds_seen != hold_asks) begin
        holds_seen = hold_asks;
        hold_left  = HOLD_CYCLES;
      end
      if (!rst_n || hold_left > 0) begin
        out_ch.ready <= 1'b0;
        if (hold_left > 0) hold_left--;
      end else begin
        out_ch.ready <= !out_idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

// ----- files.f -----
src/fer_pkg.sv
src/fer_if.sv
src/fragment_event_reassembler_unit.sv
bench/fragment_event_reassembler_unit_test.sv
